// ===== hdl/tach_pkg.sv =====
`default_nettype none
package tach_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NUMERATOR  = 2'd3;

  localparam logic [DATA_W-1:0] RST_MIN_PERIOD = 32'd33333;
  localparam logic [DATA_W-1:0] RST_MAX_PERIOD = 32'd50000;
  localparam logic [DATA_W-1:0] RST_TIMEOUT    = 32'd100000;
  localparam logic [DATA_W-1:0] RST_NUMERATOR  = 32'd120000000;

  // Input item kinds
  localparam logic KIND_EDGE   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Commands queued from the front to the back
  localparam logic [1:0] CMD_TIMEOUT = 2'd0;
  localparam logic [1:0] CMD_HOLD    = 2'd1;
  localparam logic [1:0] CMD_DIVIDE  = 2'd2;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int unsigned DIV_CNT_W = $clog2(DATA_W);

  typedef struct packed {
    logic [DATA_W-1:0] min_period;
    logic [DATA_W-1:0] max_period;
    logic [DATA_W-1:0] timeout;
    logic [DATA_W-1:0] numerator;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [TIME_W-1:0] period;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_wr_t;

  typedef struct packed {
    logic     empty;
    logic     full;
    q_entry_t entry;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== hdl/tach_if.sv =====
`default_nettype none
interface tach_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [tach_pkg::TIME_W-1:0] time_us;

  modport source (output valid, output kind, output time_us, input ready);
  modport sink (input valid, input kind, input time_us, output ready);
endinterface

interface tach_out_if;
  logic                      valid;
  logic                      ready;
  logic [tach_pkg::DATA_W-1:0] rpm;
  logic                      timed_out;

  modport source (output valid, output rpm, output timed_out, input ready);
  modport sink (input valid, input rpm, input timed_out, output ready);
endinterface
`default_nettype wire

// ===== hdl/tach_front.sv =====
`default_nettype none
module tach_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  tach_in_if.sink              in_ch,
  input  wire tach_pkg::cfg_t  cfg,
  input  wire logic            q_full,
  output tach_pkg::q_wr_t      q_wr
);

  logic [tach_pkg::TIME_W-1:0] prev_time_r, prev_time_nxt;
  logic                        have_prev_r, have_prev_nxt;
  logic [tach_pkg::TIME_W-1:0] valid_time_r, valid_time_nxt;
  logic                        have_valid_r, have_valid_nxt;
  logic [tach_pkg::TIME_W-1:0] valid_period_r, valid_period_nxt;

  logic                        accept;
  logic [tach_pkg::TIME_W-1:0] period;
  logic [tach_pkg::TIME_W-1:0] age;
  logic                        in_range;
  logic                        too_old;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Wrapping differences
  assign period   = in_ch.time_us - prev_time_r;
  assign age      = in_ch.time_us - valid_time_r;
  assign in_range = (period >= cfg.min_period) && (period <= cfg.max_period);
  assign too_old  = !have_valid_r || (age > cfg.timeout);

  always_comb begin
    prev_time_nxt    = prev_time_r;
    have_prev_nxt    = have_prev_r;
    valid_time_nxt   = valid_time_r;
    have_valid_nxt   = have_valid_r;
    valid_period_nxt = valid_period_r;
    if (accept && (in_ch.kind == tach_pkg::KIND_EDGE)) begin
      if (have_prev_r && in_range) begin
        valid_period_nxt = period;
        valid_time_nxt   = in_ch.time_us;
        have_valid_nxt   = 1'b1;
      end
      prev_time_nxt = in_ch.time_us;
      have_prev_nxt = 1'b1;
    end
  end

  // Snapshot the decision for a sample; the back only divides, replays or reports a timeout
  always_comb begin
    q_wr.push         = accept && (in_ch.kind == tach_pkg::KIND_SAMPLE);
    q_wr.entry.period = valid_period_r;
    priority if (too_old) begin
      q_wr.entry.cmd = tach_pkg::CMD_TIMEOUT;
    end else if (valid_period_r == '0) begin
      q_wr.entry.cmd = tach_pkg::CMD_HOLD;
    end else begin
      q_wr.entry.cmd = tach_pkg::CMD_DIVIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r  <= 1'b0;
      have_valid_r <= 1'b0;
    end else begin
      have_prev_r  <= have_prev_nxt;
      have_valid_r <= have_valid_nxt;
    end
    prev_time_r    <= prev_time_nxt;
    valid_time_r   <= valid_time_nxt;
    valid_period_r <= valid_period_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/tach_fifo.sv =====
`default_nettype none
module tach_fifo (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tach_pkg::q_wr_t  q_wr,
  input  wire logic             pop,
  output tach_pkg::q_stat_t     q_stat
);

  tach_pkg::q_entry_t mem_r [tach_pkg::Q_DEPTH];

  logic [tach_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tach_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tach_pkg::Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                         do_push;
  logic                         do_pop;

  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == tach_pkg::Q_CNT_W'(tach_pkg::Q_DEPTH));
  assign q_stat.entry = mem_r[rd_ptr_r];

  assign do_push = q_wr.push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == tach_pkg::Q_PTR_W'(tach_pkg::Q_DEPTH - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == tach_pkg::Q_PTR_W'(tach_pkg::Q_DEPTH - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.entry;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tach_back.sv =====
`default_nettype none
module tach_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tach_pkg::q_stat_t q_stat,
  output logic                   pop,
  input  wire logic [tach_pkg::DATA_W-1:0] numerator,
  tach_out_if.source             out_ch
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam int unsigned W = tach_pkg::DATA_W;

  logic [1:0]                       state_r, state_nxt;
  logic [W-1:0]                     quo_r, quo_nxt;
  logic [W-1:0]                     rem_r, rem_nxt;
  logic [W-1:0]                     dvs_r, dvs_nxt;
  logic [tach_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [W-1:0]                     held_r, held_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [W-1:0]                     out_rpm_r, out_rpm_nxt;
  logic                             out_to_r, out_to_nxt;

  logic                             slot_free;
  logic [W:0]                       trial;

  assign slot_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.rpm       = out_rpm_r;
  assign out_ch.timed_out = out_to_r;

  // One restoring-division step per cycle
  assign trial = {rem_r, quo_r[W-1]} - {1'b0, dvs_r};

  always_comb begin
    state_nxt     = state_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    cnt_nxt       = cnt_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r;
    out_rpm_nxt   = out_rpm_r;
    out_to_nxt    = out_to_r;
    pop           = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          unique case (q_stat.entry.cmd)
            tach_pkg::CMD_DIVIDE: begin
              pop       = 1'b1;
              quo_nxt   = numerator;
              rem_nxt   = '0;
              dvs_nxt   = q_stat.entry.period;
              cnt_nxt   = '0;
              state_nxt = S_DIV;
            end
            tach_pkg::CMD_TIMEOUT: begin
              if (slot_free) begin
                pop           = 1'b1;
                held_nxt      = '0;
                out_valid_nxt = 1'b1;
                out_rpm_nxt   = '0;
                out_to_nxt    = 1'b1;
              end
            end
            default: begin
              // hold: replay the last speed
              if (slot_free) begin
                pop           = 1'b1;
                out_valid_nxt = 1'b1;
                out_rpm_nxt   = held_r;
                out_to_nxt    = 1'b0;
              end
            end
          endcase
        end
      end
      S_DIV: begin
        if (trial[W]) begin
          rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
        end else begin
          rem_nxt = trial[W-1:0];
        end
        quo_nxt = {quo_r[W-2:0], !trial[W]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == tach_pkg::DIV_CNT_W'(W - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        held_nxt = quo_r;
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_rpm_nxt   = quo_r;
          out_to_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      held_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      held_r      <= held_nxt;
    end
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    dvs_r     <= dvs_nxt;
    cnt_r     <= cnt_nxt;
    out_rpm_r <= out_rpm_nxt;
    out_to_r  <= out_to_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/pulse_period_tachometer.sv =====
// Edge items: accepted one per cycle while the queue has room, no result; the front
// updates period state at once.
// Sample items: the result is registered in the output slot for timeout or hold; when a
// divide runs it passes through load, 32 one-bit steps and output, and the back takes no
// new sample until the divide is through.
// A two-entry sample queue lets edges keep flowing while a divide is in progress, until it fills.
// Synchronous active-low reset restores register defaults and clears all edge history.
`default_nettype none
module pulse_period_tachometer (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  tach_in_if.sink                                in_ch,
  tach_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [tach_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tach_pkg::DATA_W-1:0]       cfg_data
);

  tach_pkg::cfg_t    cfg_r;
  tach_pkg::q_wr_t   q_wr;
  tach_pkg::q_stat_t q_stat;
  logic              pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_period <= tach_pkg::RST_MIN_PERIOD;
      cfg_r.max_period <= tach_pkg::RST_MAX_PERIOD;
      cfg_r.timeout    <= tach_pkg::RST_TIMEOUT;
      cfg_r.numerator  <= tach_pkg::RST_NUMERATOR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tach_pkg::REG_MIN_PERIOD: cfg_r.min_period <= cfg_data;
        tach_pkg::REG_MAX_PERIOD: cfg_r.max_period <= cfg_data;
        tach_pkg::REG_TIMEOUT:    cfg_r.timeout    <= cfg_data;
        tach_pkg::REG_NUMERATOR:  cfg_r.numerator  <= cfg_data;
        default: ;
      endcase
    end
  end

  tach_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg_r),
    .q_full (q_stat.full),
    .q_wr   (q_wr)
  );

  tach_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .pop    (pop),
    .q_stat (q_stat)
  );

  tach_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop       (pop),
    .numerator (cfg_r.numerator),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
